/* sv/i2cbe_pkg.sv */
// ----------------------------------------------------------------------------
// i2cbe_pkg: shared types and constants of the I2C master bit engine
// Phase codes, command and status codes, and the group types that pass
// between the sequencer, the timeout timer and the top level.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

	localparam int DELAY_WIDTH_DEF   = 16;
	localparam int TIMEOUT_WIDTH_DEF = 32;

	localparam int PHASE_DELAY_W = 16;
	localparam int TIMEOUT_REG_W = 32;
	localparam int CFG_DATA_W    = 32;
	localparam int CFG_INDEX_W   = 1;

	localparam logic [PHASE_DELAY_W-1:0] PHASE_DELAY_RST = 16'd30;
	localparam logic [TIMEOUT_REG_W-1:0] TIMEOUT_RST     = 32'd48000;

	localparam int S_TDATA_W = 16;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 16;

	localparam logic [7:0] MSB_MASK      = 8'h80;
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PHASE_DELAY = 1'b0,
		CFG_TIMEOUT     = 1'b1
	} cfg_index_t;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_NACK     = 2'd1,
		STAT_LINE_ERR = 2'd2,
		STAT_TIMEOUT  = 2'd3
	} stat_t;

	typedef enum logic [16:0] {
		PH_IDLE  = 17'h00001,
		PH_ST_D1 = 17'h00002,
		PH_ST_D2 = 17'h00004,
		PH_SP_D1 = 17'h00008,
		PH_SP_D2 = 17'h00010,
		PH_SP_D3 = 17'h00020,
		PH_W_D1  = 17'h00040,
		PH_W_D2  = 17'h00080,
		PH_W_STR = 17'h00100,
		PH_W_A1  = 17'h00200,
		PH_W_A2  = 17'h00400,
		PH_W_A3  = 17'h00800,
		PH_R_D1  = 17'h01000,
		PH_R_D2  = 17'h02000,
		PH_R_STR = 17'h04000,
		PH_R_A1  = 17'h08000,
		PH_R_A2  = 17'h10000
	} phase_t;

	typedef struct packed {
		logic step;
		logic clear;
	} tmr_ctl_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
		logic [7:0] read_data;
	} result_t;

endpackage

/* sv/i2c_master_bit_engine_core.sv */
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_core: I2C master bit engine
// One request per bus sampling tick; each gives one result with the
// open-drain drives, busy, done, status and the last read byte.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata, s_tuser (tick and command)
//   m_*      out  m_tvalid/m_tready  m_tdata (drives and status)
//   cfg_*    in   cfg_we             cfg_index, cfg_wdata
//
// one request per cycle unless stalled; result on m_tdata the cycle after accept
// the output register lets a new request in while the last result is taken
// when the output register is full and m_tready is low, s_tready drops
// reset clears the phase machine, counters, drives and config to defaults
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_core #(
	parameter int DELAY_WIDTH   = i2cbe_pkg::DELAY_WIDTH_DEF,
	parameter int TIMEOUT_WIDTH = i2cbe_pkg::TIMEOUT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// scl_in, sda_in, cmd_valid, write_data[7:0], send_ack, zero fill
	input  logic [i2cbe_pkg::S_TDATA_W-1:0]     s_tdata,
	// operation[1:0]
	input  logic [i2cbe_pkg::S_TUSER_W-1:0]     s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// scl_drive_low, sda_drive_low, busy_res, done_res, status[1:0],
	// read_data[7:0], zero fill
	output logic [i2cbe_pkg::M_TDATA_W-1:0]     m_tdata,
	input  logic                                cfg_we,
	input  logic [i2cbe_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [i2cbe_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import i2cbe_pkg::*;

	logic [PHASE_DELAY_W-1:0] phase_delay_q;
	logic [TIMEOUT_REG_W-1:0] timeout_q;
	logic [DELAY_WIDTH-1:0]   delay_raw;
	logic [DELAY_WIDTH-1:0]   delay_target;
	logic                     accept;
	logic                     expired;
	logic                     start_clear;
	tmr_ctl_t                 tmr_ctl;
	result_t                  result;
	logic                     m_tvalid_q;
	logic [M_TDATA_W-1:0]     m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_delay_q <= PHASE_DELAY_RST;
			timeout_q     <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PHASE_DELAY: phase_delay_q <= cfg_wdata[PHASE_DELAY_W-1:0];
				CFG_TIMEOUT:     timeout_q     <= cfg_wdata[TIMEOUT_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// zero delay acts as one tick
	assign delay_raw    = DELAY_WIDTH'(phase_delay_q);
	assign delay_target = (delay_raw == '0) ? DELAY_WIDTH'(1) : delay_raw;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign tmr_ctl.step  = accept;
	assign tmr_ctl.clear = start_clear;

	i2cbe_timer #(
		.TIMEOUT_WIDTH(TIMEOUT_WIDTH)
	) u_timer (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (tmr_ctl),
		.timeout_ticks(timeout_q),
		.expired      (expired)
	);

	i2cbe_seq #(
		.DELAY_WIDTH(DELAY_WIDTH)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.scl_in      (s_tdata[0]),
		.sda_in      (s_tdata[1]),
		.cmd_valid   (s_tdata[2]),
		.operation   (s_tuser[1:0]),
		.write_data  (s_tdata[10:3]),
		.send_ack    (s_tdata[11]),
		.delay_target(delay_target),
		.expired     (expired),
		.start_clear (start_clear),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {2'b00, result.read_data, result.status, result.done_res,
				result.busy_res, result.sda_drive_low, result.scl_drive_low};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

/* sv/i2cbe_timer.sv */
// ----------------------------------------------------------------------------
// i2cbe_timer: clock-stretch timeout counter
// Saturating tick counter, cleared on an accepted start, with the expiry
// flag taken from the value after this tick's increment.
// ----------------------------------------------------------------------------
module i2cbe_timer #(
	parameter int TIMEOUT_WIDTH = i2cbe_pkg::TIMEOUT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  i2cbe_pkg::tmr_ctl_t                 ctl,
	input  logic [i2cbe_pkg::TIMEOUT_REG_W-1:0] timeout_ticks,
	output logic                                expired
);
	import i2cbe_pkg::*;

	logic [TIMEOUT_WIDTH-1:0] count_q;
	logic [TIMEOUT_WIDTH-1:0] count_inc;
	logic [TIMEOUT_WIDTH-1:0] limit;

	assign limit     = TIMEOUT_WIDTH'(timeout_ticks);
	assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
	assign expired   = count_inc >= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.step) begin
			count_q <= ctl.clear ? '0 : count_inc;
		end
	end

endmodule

/* sv/i2cbe_seq.sv */
// ----------------------------------------------------------------------------
// i2cbe_seq: bit-level phase sequencer
// Steps the phase machine once per accepted tick and forms that tick's
// line drives and status from the updated state.
// ----------------------------------------------------------------------------
module i2cbe_seq #(
	parameter int DELAY_WIDTH = i2cbe_pkg::DELAY_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic                   scl_in,
	input  logic                   sda_in,
	input  logic                   cmd_valid,
	input  logic [1:0]             operation,
	input  logic [7:0]             write_data,
	input  logic                   send_ack,
	input  logic [DELAY_WIDTH-1:0] delay_target,
	input  logic                   expired,
	output logic                   start_clear,
	output i2cbe_pkg::result_t     result
);
	import i2cbe_pkg::*;

	phase_t                 phase_q, phase_n;
	logic [3:0]             bit_q, bit_n;
	logic [7:0]             shift_q, shift_n;
	logic [DELAY_WIDTH-1:0] dcnt_q, dcnt_n, dcnt_inc;
	logic                   ack_q, ack_n;
	logic                   scl_q, scl_n;
	logic                   sda_q, sda_n;
	logic [1:0]             stat_q, stat_n;
	logic [7:0]             rhold_q, rhold_n;
	logic                   done;
	logic                   hit;

	assign dcnt_inc = dcnt_q + 1'b1;
	assign hit      = dcnt_inc >= delay_target;

	always_comb begin
		phase_n     = phase_q;
		bit_n       = bit_q;
		shift_n     = shift_q;
		dcnt_n      = dcnt_q;
		ack_n       = ack_q;
		scl_n       = scl_q;
		sda_n       = sda_q;
		stat_n      = stat_q;
		rhold_n     = rhold_q;
		done        = 1'b0;
		start_clear = 1'b0;

		if (phase_q inside {PH_ST_D1, PH_ST_D2, PH_SP_D1, PH_SP_D2, PH_SP_D3,
				PH_W_D1, PH_W_D2, PH_W_A1, PH_W_A2, PH_W_A3,
				PH_R_D1, PH_R_D2, PH_R_A1, PH_R_A2}) begin
			dcnt_n = hit ? '0 : dcnt_inc;
		end

		case (phase_q)
			PH_IDLE: begin
				if (cmd_valid) begin
					dcnt_n = '0;
					case (op_t'(operation))
						OP_START: begin
							start_clear = 1'b1;
							if (!sda_in || !scl_in) begin
								stat_n = STAT_LINE_ERR;
								done   = 1'b1;
							end else begin
								sda_n   = 1'b1;
								phase_n = PH_ST_D1;
							end
						end
						OP_STOP: begin
							sda_n   = 1'b1;
							phase_n = PH_SP_D1;
						end
						OP_WRITE: begin
							shift_n = write_data;
							bit_n   = '0;
							sda_n   = (write_data & MSB_MASK) == 8'h00;
							phase_n = PH_W_D1;
						end
						default: begin
							sda_n   = 1'b0;
							bit_n   = '0;
							shift_n = '0;
							ack_n   = send_ack;
							phase_n = PH_R_D1;
						end
					endcase
				end
			end
			PH_ST_D1: begin
				if (hit) begin
					scl_n   = 1'b1;
					phase_n = PH_ST_D2;
				end
			end
			PH_ST_D2: begin
				if (hit) begin
					stat_n  = (sda_in || scl_in) ? STAT_LINE_ERR : STAT_OK;
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			PH_SP_D1: begin
				if (hit) begin
					scl_n   = 1'b0;
					phase_n = PH_SP_D2;
				end
			end
			PH_SP_D2: begin
				if (hit) begin
					sda_n   = 1'b0;
					phase_n = PH_SP_D3;
				end
			end
			PH_SP_D3: begin
				if (hit) begin
					stat_n  = STAT_OK;
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			PH_W_D1: begin
				if (hit) begin
					scl_n   = 1'b0;
					phase_n = PH_W_D2;
				end
			end
			PH_W_D2: begin
				if (hit) begin
					phase_n = PH_W_STR;
				end
			end
			PH_W_STR: begin
				if (scl_in) begin
					scl_n   = 1'b1;
					shift_n = {shift_q[6:0], 1'b0};
					bit_n   = bit_q + 1'b1;
					dcnt_n  = '0;
					if (bit_n >= BITS_PER_BYTE) begin
						phase_n = PH_W_A1;
					end else begin
						sda_n   = (shift_n & MSB_MASK) == 8'h00;
						phase_n = PH_W_D1;
					end
				end else if (expired) begin
					stat_n  = STAT_TIMEOUT;
					done    = 1'b1;
					dcnt_n  = '0;
					phase_n = PH_IDLE;
				end
			end
			PH_W_A1: begin
				if (hit) begin
					sda_n   = 1'b0;
					phase_n = PH_W_A2;
				end
			end
			PH_W_A2: begin
				if (hit) begin
					scl_n   = 1'b0;
					phase_n = PH_W_A3;
				end
			end
			PH_W_A3: begin
				if (hit) begin
					scl_n   = 1'b1;
					sda_n   = 1'b1;
					stat_n  = sda_in ? STAT_NACK : STAT_OK;
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			PH_R_D1: begin
				if (hit) begin
					scl_n   = 1'b0;
					phase_n = PH_R_D2;
				end
			end
			PH_R_D2: begin
				if (hit) begin
					phase_n = PH_R_STR;
				end
			end
			PH_R_STR: begin
				if (scl_in) begin
					shift_n = {shift_q[6:0], sda_in};
					scl_n   = 1'b1;
					bit_n   = bit_q + 1'b1;
					dcnt_n  = '0;
					if (bit_n >= BITS_PER_BYTE) begin
						if (ack_q) begin
							sda_n = 1'b1;
						end
						phase_n = PH_R_A1;
					end else begin
						phase_n = PH_R_D1;
					end
				end else if (expired) begin
					stat_n  = STAT_TIMEOUT;
					done    = 1'b1;
					dcnt_n  = '0;
					phase_n = PH_IDLE;
				end
			end
			PH_R_A1: begin
				if (hit) begin
					scl_n   = 1'b0;
					phase_n = PH_R_A2;
				end
			end
			PH_R_A2: begin
				if (hit) begin
					scl_n   = 1'b1;
					sda_n   = 1'b0;
					rhold_n = shift_q;
					stat_n  = STAT_OK;
					done    = 1'b1;
					phase_n = PH_IDLE;
				end
			end
			default: begin
				phase_n = PH_IDLE;
				dcnt_n  = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			bit_q   <= '0;
			shift_q <= '0;
			dcnt_q  <= '0;
			ack_q   <= 1'b0;
			scl_q   <= 1'b0;
			sda_q   <= 1'b0;
			stat_q  <= STAT_OK;
			rhold_q <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			bit_q   <= bit_n;
			shift_q <= shift_n;
			dcnt_q  <= dcnt_n;
			ack_q   <= ack_n;
			scl_q   <= scl_n;
			sda_q   <= sda_n;
			stat_q  <= stat_n;
			rhold_q <= rhold_n;
		end
	end

	assign result.scl_drive_low = scl_n;
	assign result.sda_drive_low = sda_n;
	assign result.busy_res      = phase_n != PH_IDLE;
	assign result.done_res      = done;
	assign result.status        = stat_n;
	assign result.read_data     = rhold_n;

endmodule
